>>> hdl/fmps_pkg.sv
// Shared types, constants and reciprocal tables for the Fourier mode phase shifter.
package fmps_pkg;

	// Mode pair range; pairs at or beyond it pass unchanged
	localparam int MODE_PAIRS = 256;

	// Polynomial term counts for the sine and cosine series
	localparam int SIN_TERMS = 5;
	localparam int COS_TERMS = 6;

	// Pipeline depth: front end, two stages per cell, rotator
	localparam int FRONT_STAGES = 3;
	localparam int ROT_STAGES = 5;
	localparam int LATENCY = FRONT_STAGES + 2 * COS_TERMS + ROT_STAGES;

	// Fixed-point constants
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [29:0] OCT_SPAN = 30'h2000_0000;
	localparam logic [61:0] TH_HALF = 62'h1000_0000;

	// Configuration register indexes
	localparam logic [0:0] REG_SHIFT_FRACTION = 1'b0;
	localparam logic [0:0] REG_ZERO_MODE_COMPLEX = 1'b1;

	// Quadrant codes of the phase
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Exact floor division by a small constant: q = (p * rcp) >> sh
	typedef struct packed {
		logic [33:0] rcp;
		logic [5:0]  sh;
	} recip_t;

	// rcp = ceil(2^sh / d), sh = 32 + ceil(log2 d)
	localparam recip_t SIN_K [SIN_TERMS] = '{
		'{34'(((66'd1 << 39) + 66'd109) / 66'd110), 6'd39},
		'{34'(((66'd1 << 39) + 66'd71) / 66'd72), 6'd39},
		'{34'(((66'd1 << 38) + 66'd41) / 66'd42), 6'd38},
		'{34'(((66'd1 << 37) + 66'd19) / 66'd20), 6'd37},
		'{34'(((66'd1 << 35) + 66'd5) / 66'd6), 6'd35}
	};

	localparam recip_t COS_K [COS_TERMS] = '{
		'{34'(((66'd1 << 40) + 66'd131) / 66'd132), 6'd40},
		'{34'(((66'd1 << 39) + 66'd89) / 66'd90), 6'd39},
		'{34'(((66'd1 << 38) + 66'd55) / 66'd56), 6'd38},
		'{34'(((66'd1 << 37) + 66'd29) / 66'd30), 6'd37},
		'{34'(((66'd1 << 36) + 66'd11) / 66'd12), 6'd36},
		'{34'(((66'd1 << 33) + 66'd1) / 66'd2), 6'd33}
	};

	// Per-word side data carried down the pipeline
	typedef struct packed {
		logic               bypass;
		logic               odd;
		logic [1:0]         quad;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} side_t;

	// Word handed from cell to cell
	typedef struct packed {
		logic [31:0] th;
		logic [31:0] t;
		logic [32:0] u_sin;
		logic [32:0] u_cos;
		side_t       side;
	} cell_t;

endpackage

>>> hdl/fourier_mode_phase_shift.sv
// Throughput: one word per cycle; busy stays low and start may be high in every cycle.
// Depth is set by the row of six polynomial cells (two stages each) plus front and rotator.
// The receiver cannot stall: each result is on the ports for exactly one cycle with done.
// Reset (arst_n low) clears all valid flags, shift_fraction and zero_mode_complex at once.
module fourier_mode_phase_shift (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         mode_pair,
	input  logic signed [31:0] real_in,
	input  logic signed [31:0] imag_in,
	output logic               done,
	output logic signed [31:0] real_out,
	output logic signed [31:0] imag_out,
	output logic               clipped,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0]     shift_fraction_q;
	logic            zmc_q;
	logic            chain_valid [fmps_pkg::COS_TERMS + 1];
	fmps_pkg::cell_t chain_data [fmps_pkg::COS_TERMS + 1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_fraction_q <= 32'd0;
			zmc_q            <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fmps_pkg::REG_SHIFT_FRACTION: shift_fraction_q <= cfg_data;
				fmps_pkg::REG_ZERO_MODE_COMPLEX: zmc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Phase, octant and angle
	fmps_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (start && !busy),
		.mode_pair         (mode_pair),
		.real_in           (real_in),
		.imag_in           (imag_in),
		.shift_fraction    (shift_fraction_q),
		.zero_mode_complex (zmc_q),
		.out_valid         (chain_valid[0]),
		.out_data          (chain_data[0])
	);

	// Row of series cells; the sine series starts one cell later
	for (genvar k = 0; k < fmps_pkg::COS_TERMS; k++) begin : g_cell
		fmps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_data   (chain_data[k]),
			.sin_en    (1'(k != 0)),
			.sin_k     (fmps_pkg::SIN_K[(k == 0) ? 0 : k - 1]),
			.cos_k     (fmps_pkg::COS_K[k]),
			.out_valid (chain_valid[k + 1]),
			.out_data  (chain_data[k + 1])
		);
	end

	// Rotation and output register
	fmps_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[fmps_pkg::COS_TERMS]),
		.in_data   (chain_data[fmps_pkg::COS_TERMS]),
		.out_valid (done),
		.real_out  (real_out),
		.imag_out  (imag_out),
		.clipped   (clipped)
	);

`ifndef SYNTHESIS
	// Every result with done traces back to a word taken on start
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, fmps_pkg::LATENCY))
		else $error("result without a matching input word");

	// A clip flag always comes with a bound value on one of the parts
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> (real_out == 32'sh7FFF_FFFF || real_out == 32'sh8000_0000 ||
			imag_out == 32'sh7FFF_FFFF || imag_out == 32'sh8000_0000))
		else $error("clip flag without a saturated part");

	// Packed real pair leaves exactly as it came in
	a_packed_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !zmc_q && mode_pair == 8'd0, fmps_pkg::LATENCY) |->
			real_out == $past(real_in, fmps_pkg::LATENCY) &&
			imag_out == $past(imag_in, fmps_pkg::LATENCY) && !clipped)
		else $error("packed real pair was altered");
`endif

endmodule

>>> hdl/fmps_cell.sv
// One polynomial cell: a Horner step of the sine and cosine series.
module fmps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fmps_pkg::cell_t     in_data,
	input  logic                sin_en,
	input  fmps_pkg::recip_t    sin_k,
	input  fmps_pkg::recip_t    cos_k,
	output logic                out_valid,
	output fmps_pkg::cell_t     out_data
);

	logic [63:0]     sin_prod, cos_prod;
	logic [31:0]     sin_p, cos_p;
	logic            valid_s1, valid_s2;
	fmps_pkg::cell_t data_s1, data_s2;
	logic [31:0]     sin_p_s1, cos_p_s1;
	logic [65:0]     sin_qp, cos_qp;
	logic [32:0]     sin_q, cos_q;
	logic [32:0]     u_sin_nx, u_cos_nx;

	// First half: floor(t * u / 2^32), u is at most 2^32
	always_comb begin
		sin_prod = in_data.t * in_data.u_sin[31:0];
		cos_prod = in_data.t * in_data.u_cos[31:0];
		sin_p = sin_prod[63:32] + (in_data.u_sin[32] ? in_data.t : 32'd0);
		cos_p = cos_prod[63:32] + (in_data.u_cos[32] ? in_data.t : 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1  <= in_data;
		sin_p_s1 <= sin_p;
		cos_p_s1 <= cos_p;
	end

	// Second half: divide by the term's constant, u = 1 - p / d; u_sin passes through when sin_en is low
	always_comb begin
		sin_qp = sin_p_s1 * sin_k.rcp;
		cos_qp = cos_p_s1 * cos_k.rcp;
		sin_q = 33'(sin_qp >> sin_k.sh);
		cos_q = 33'(cos_qp >> cos_k.sh);
		u_sin_nx = sin_en ? fmps_pkg::ONE_Q32 - sin_q : data_s1.u_sin;
		u_cos_nx = fmps_pkg::ONE_Q32 - cos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2.th    <= data_s1.th;
		data_s2.t     <= data_s1.t;
		data_s2.u_sin <= u_sin_nx;
		data_s2.u_cos <= u_cos_nx;
		data_s2.side  <= data_s1.side;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

>>> hdl/fmps_front.sv
// Front end: phase from mode pair and shift, octant fold, angle and its square.
module fmps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          mode_pair,
	input  logic signed [31:0]  real_in,
	input  logic signed [31:0]  imag_in,
	input  logic [31:0]         shift_fraction,
	input  logic                zero_mode_complex,
	output logic                out_valid,
	output fmps_pkg::cell_t     out_data
);

	logic [8:0]      mult;
	logic [40:0]     mprod;
	logic [31:0]     phase;
	fmps_pkg::side_t side;
	logic            valid_s1, valid_s2, valid_s3;
	logic [28:0]     r_s1;
	fmps_pkg::side_t side_s1, side_s2, side_s3;
	logic [29:0]     rr;
	logic [61:0]     th_prod, th_sum;
	logic [31:0]     th_s2, th_s3;
	logic [63:0]     sq_prod;
	logic [31:0]     t_s3;

	// Stage 1: multiplier and phase modulo one turn
	always_comb begin
		mult  = 9'(mode_pair) + 9'(zero_mode_complex);
		mprod = mult * shift_fraction;
		phase = mprod[31:0];
		side.bypass = (!zero_mode_complex && mode_pair == 8'd0) ||
			(32'(mode_pair) >= fmps_pkg::MODE_PAIRS);
		side.odd  = phase[29];
		side.quad = phase[31:30];
		side.re   = real_in;
		side.im   = imag_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s1    <= phase[28:0];
		side_s1 <= side;
	end

	// Stage 2: fold odd octants, angle in Q32 radians
	always_comb begin
		rr = side_s1.odd ? fmps_pkg::OCT_SPAN - {1'b0, r_s1} : {1'b0, r_s1};
		th_prod = rr * fmps_pkg::PI_Q30;
		th_sum  = th_prod + fmps_pkg::TH_HALF;
	end

	always_ff @(posedge clk) begin
		th_s2   <= th_sum[60:29];
		side_s2 <= side_s1;
	end

	// Stage 3: square of the angle
	assign sq_prod = th_s2 * th_s2;

	always_ff @(posedge clk) begin
		t_s3    <= sq_prod[63:32];
		th_s3   <= th_s2;
		side_s3 <= side_s2;
	end

	always_comb begin
		out_data.th    = th_s3;
		out_data.t     = t_s3;
		out_data.u_sin = fmps_pkg::ONE_Q32;
		out_data.u_cos = fmps_pkg::ONE_Q32;
		out_data.side  = side_s3;
	end

	assign out_valid = valid_s3;

endmodule

>>> hdl/fmps_rotate.sv
// Rotator: final sine product, quadrant signs, complex multiply, round and saturate.
module fmps_rotate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fmps_pkg::cell_t     in_data,
	output logic                out_valid,
	output logic signed [31:0]  real_out,
	output logic signed [31:0]  imag_out,
	output logic                clipped
);

	logic [63:0]        s_prod;
	logic [32:0]        s_full;
	logic [33:0]        s_rnd, c_rnd;
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [30:0]        s30_s1, c30_s1;
	fmps_pkg::side_t    side_s1, side_s2, side_s3, side_s4;
	logic signed [31:0] s_pos, c_pos, sa, ca, cs, sn;
	logic signed [31:0] cs_s2, sn_s2;
	logic signed [63:0] rc_s3, is_s3, rs_s3, ic_s3;
	logic signed [63:0] ro_s4, io_s4;
	logic [32:0]        ro_sat, io_sat;
	logic               done_q, clip_q;
	logic signed [31:0] real_q, imag_q;

	// Round off the Q30 fraction with halves up, clamp to 32 bits; bit 32 flags a clamp
	function automatic logic [32:0] round_sat(input logic signed [63:0] v);
		logic signed [64:0] b;
		logic signed [34:0] q;
		logic [32:0]        res;
		b = 65'(v) + 65'sd536870912;
		q = b[64:30];
		if (q > 35'sd2147483647) begin
			res = {1'b1, 32'h7FFF_FFFF};
		end else if (q < -35'sd2147483648) begin
			res = {1'b1, 32'h8000_0000};
		end else begin
			res = {1'b0, q[31:0]};
		end
		return res;
	endfunction

	// Stage 1: sine = theta * u, both converted to Q30
	always_comb begin
		s_prod = in_data.th * in_data.u_sin[31:0];
		s_full = 33'(s_prod[63:32]) + (in_data.u_sin[32] ? 33'(in_data.th) : 33'd0);
		s_rnd  = 34'(s_full) + 34'd2;
		c_rnd  = 34'(in_data.u_cos) + 34'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		s30_s1  <= s_rnd[32:2];
		c30_s1  <= c_rnd[32:2];
		side_s1 <= in_data.side;
	end

	// Stage 2: octant swap and quadrant signs
	always_comb begin
		s_pos = $signed({1'b0, s30_s1});
		c_pos = $signed({1'b0, c30_s1});
		sa = side_s1.odd ? c_pos : s_pos;
		ca = side_s1.odd ? s_pos : c_pos;
		case (side_s1.quad)
			fmps_pkg::QUAD_0: begin
				cs = ca;
				sn = sa;
			end
			fmps_pkg::QUAD_1: begin
				cs = -sa;
				sn = ca;
			end
			fmps_pkg::QUAD_2: begin
				cs = -ca;
				sn = -sa;
			end
			fmps_pkg::QUAD_3: begin
				cs = sa;
				sn = -ca;
			end
			default: begin
				cs = ca;
				sn = sa;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cs_s2   <= cs;
		sn_s2   <= sn;
		side_s2 <= side_s1;
	end

	// Stage 3: four partial products
	always_ff @(posedge clk) begin
		rc_s3   <= $signed(side_s2.re) * cs_s2;
		is_s3   <= $signed(side_s2.im) * sn_s2;
		rs_s3   <= $signed(side_s2.re) * sn_s2;
		ic_s3   <= $signed(side_s2.im) * cs_s2;
		side_s3 <= side_s2;
	end

	// Stage 4: exact complex sums
	always_ff @(posedge clk) begin
		ro_s4   <= rc_s3 - is_s3;
		io_s4   <= rs_s3 + ic_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: round, saturate, or pass the input word through
	always_comb begin
		ro_sat = round_sat(ro_s4);
		io_sat = round_sat(io_s4);
	end

	always_ff @(posedge clk) begin
		if (side_s4.bypass) begin
			real_q <= side_s4.re;
			imag_q <= side_s4.im;
			clip_q <= 1'b0;
		end else begin
			real_q <= $signed(ro_sat[31:0]);
			imag_q <= $signed(io_sat[31:0]);
			clip_q <= ro_sat[32] | io_sat[32];
		end
	end

	assign out_valid = done_q;
	assign real_out  = real_q;
	assign imag_out  = imag_q;
	assign clipped   = clip_q;

endmodule
